>>> rtl/modbus_ascii_frame_decoder_core_defines.svh
// Assertion macros for the Modbus ASCII frame decoder.
`ifndef MODBUS_ASCII_FRAME_DECODER_CORE_DEFINES_SVH
`define MODBUS_ASCII_FRAME_DECODER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define MAFD_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion lbl failed");
`define MAFD_ASSERT_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("assertion lbl failed");
`else
`define MAFD_ASSERT(lbl, clk, rstn, prop)
`define MAFD_ASSERT_NEVER(lbl, clk, rstn, expr)
`endif

`endif

>>> rtl/mafd_pkg.sv
// Shared types and constants of the Modbus ASCII frame decoder.
package mafd_pkg;

    localparam logic [7:0] MAX_LEN_RESET = 8'd20;
    localparam int         OUTQ_DEPTH    = 4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FORMAT   = 2'd1;
    localparam logic [1:0] ST_TOO_LONG = 2'd2;
    localparam logic [1:0] ST_MISMATCH = 2'd3;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
        logic [7:0] frame_address;
        logic [7:0] frame_function;
        logic [7:0] data_count;
        logic [1:0] status;
    } result_t;

endpackage

>>> rtl/mafd_step.sv
// Input register, frame state and per-character decode step.
module mafd_step (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [7:0]        cfg_data,
    input  logic              in_valid,
    input  logic [7:0]        in_char,
    output logic              in_flight,
    output logic              res_valid,
    output mafd_pkg::result_t res
);
    import mafd_pkg::*;

    localparam logic [3:0] PH_IDLE    = 4'd0;
    localparam logic [3:0] PH_ADDR_HI = 4'd1;
    localparam logic [3:0] PH_ADDR_LO = 4'd2;
    localparam logic [3:0] PH_FUNC_HI = 4'd3;
    localparam logic [3:0] PH_FUNC_LO = 4'd4;
    localparam logic [3:0] PH_BODY_HI = 4'd5;
    localparam logic [3:0] PH_BODY_LO = 4'd6;
    localparam logic [3:0] PH_WAIT_LF = 4'd7;

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    function automatic logic [3:0] digit_value(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            v = c[3:0];
        end
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
        begin
            v = c[3:0] + 4'd9;
        end
        return v;
    endfunction

    logic       in_valid_reg;
    logic [7:0] in_char_reg;
    logic [7:0] max_len_reg;
    logic [3:0] phase_reg,  phase_next;
    logic [3:0] nib_reg,    nib_next;
    logic [7:0] addr_reg,   addr_next;
    logic [7:0] func_reg,   func_next;
    logic [7:0] pend_reg,   pend_next;
    logic       pend_valid_reg, pend_valid_next;
    logic [7:0] sum_reg,    sum_next;
    logic [7:0] count_reg,  count_next;
    logic [1:0] err_reg,    err_next;

    logic       do_start;
    logic [3:0] d;
    logic [7:0] b;
    logic [1:0] final_status;

    assign d = digit_value(in_char_reg);
    assign b = {nib_reg, d};
    assign final_status = (err_reg != ST_OK) ? err_reg :
                          ((sum_reg == pend_reg) ? ST_OK : ST_MISMATCH);
    assign in_flight = in_valid_reg;

    always_comb
    begin
        phase_next      = phase_reg;
        nib_next        = nib_reg;
        addr_next       = addr_reg;
        func_next       = func_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        sum_next        = sum_reg;
        count_next      = count_reg;
        err_next        = err_reg;
        do_start        = 1'b0;
        res_valid       = 1'b0;
        res.kind           = 1'b1;
        res.data_byte      = 8'd0;
        res.frame_address  = addr_reg;
        res.frame_function = func_reg;
        res.data_count     = count_reg;
        res.status         = ST_OK;

        if (in_valid_reg)
        begin
            if (phase_reg < PH_ADDR_HI || phase_reg > PH_WAIT_LF)
            begin
                phase_next = PH_IDLE;
                do_start   = (in_char_reg == CH_COLON);
            end
            else if (in_char_reg == CH_COLON)
            begin
                res_valid  = 1'b1;
                res.status = ST_FORMAT;
                do_start   = 1'b1;
            end
            else if (phase_reg == PH_WAIT_LF)
            begin
                res_valid  = 1'b1;
                res.status = (in_char_reg == CH_LF) ? final_status : ST_FORMAT;
                phase_next = PH_IDLE;
            end
            else if (in_char_reg == CH_CR)
            begin
                if (phase_reg != PH_BODY_HI || !pend_valid_reg)
                begin
                    err_next = ST_FORMAT;
                end
                phase_next = PH_WAIT_LF;
            end
            else if (phase_reg == PH_ADDR_HI || phase_reg == PH_FUNC_HI ||
                     phase_reg == PH_BODY_HI)
            begin
                nib_next   = d;
                phase_next = phase_reg + 4'd1;
            end
            else if (phase_reg == PH_ADDR_LO)
            begin
                addr_next  = b;
                sum_next   = sum_reg + b;
                phase_next = PH_FUNC_HI;
            end
            else if (phase_reg == PH_FUNC_LO)
            begin
                func_next  = b;
                sum_next   = sum_reg + b;
                phase_next = PH_BODY_HI;
            end
            else if (phase_reg == PH_BODY_LO)
            begin
                phase_next = PH_BODY_HI;
                pend_next  = b;
                if (!pend_valid_reg)
                begin
                    pend_valid_next = 1'b1;
                end
                else
                begin
                    sum_next = sum_reg + pend_reg;
                    if (count_reg < max_len_reg)
                    begin
                        count_next     = count_reg + 8'd1;
                        res_valid      = 1'b1;
                        res.kind       = 1'b0;
                        res.data_byte  = pend_reg;
                        res.data_count = count_reg + 8'd1;
                    end
                    else
                    begin
                        if (count_reg == max_len_reg && max_len_reg != 8'hFF)
                        begin
                            count_next = count_reg + 8'd1;
                        end
                        if (err_reg == ST_OK)
                        begin
                            err_next = ST_TOO_LONG;
                        end
                    end
                end
            end
        end

        if (do_start)
        begin
            phase_next      = PH_ADDR_HI;
            nib_next        = 4'd0;
            addr_next       = 8'd0;
            func_next       = 8'd0;
            pend_next       = 8'd0;
            pend_valid_next = 1'b0;
            sum_next        = 8'd0;
            count_next      = 8'd0;
            err_next        = ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            max_len_reg    <= MAX_LEN_RESET;
            phase_reg      <= PH_IDLE;
            nib_reg        <= 4'd0;
            addr_reg       <= 8'd0;
            func_reg       <= 8'd0;
            pend_reg       <= 8'd0;
            pend_valid_reg <= 1'b0;
            sum_reg        <= 8'd0;
            count_reg      <= 8'd0;
            err_reg        <= ST_OK;
        end
        else
        begin
            in_valid_reg   <= in_valid;
            if (cfg_we)
            begin
                max_len_reg <= cfg_data;
            end
            phase_reg      <= phase_next;
            nib_reg        <= nib_next;
            addr_reg       <= addr_next;
            func_reg       <= func_next;
            pend_reg       <= pend_next;
            pend_valid_reg <= pend_valid_next;
            sum_reg        <= sum_next;
            count_reg      <= count_next;
            err_reg        <= err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            in_char_reg <= in_char;
        end
    end

endmodule

>>> rtl/mafd_outq.sv
// Small result queue between the decode step and the output stream.
module mafd_outq #(
    parameter int DEPTH = mafd_pkg::OUTQ_DEPTH
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  mafd_pkg::result_t          push_data,
    input  logic                       out_ready,
    output logic                       out_valid,
    output mafd_pkg::result_t          out_data,
    output logic [$clog2(DEPTH+1)-1:0] level
);
    import mafd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LVL_W = $clog2(DEPTH + 1);

    result_t            mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [LVL_W-1:0]   count_reg, count_next;
    logic               pop;

    assign out_valid = (count_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    assign level     = count_reg;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

`include "modbus_ascii_frame_decoder_core_defines.svh"

    `MAFD_ASSERT_NEVER(a_no_overflow, clk, rst_n, (count_reg == LVL_W'(DEPTH)) && push && !pop)
    `MAFD_ASSERT(a_empty_ptrs, clk, rst_n, (count_reg == '0) |-> (rd_ptr_reg == wr_ptr_reg))
    `MAFD_ASSERT(a_pop_count, clk, rst_n, (pop && !push) |=> (count_reg == $past(count_reg) - 1'b1))

endmodule

>>> rtl/modbus_ascii_frame_decoder_core.sv
// Top level of the Modbus ASCII frame decoder.
//
//  channel   dir  payload                                  handshake
//  s_*       in   tdata[7:0] char_in                       tvalid/tready
//  m_*       out  tdata data/addr/func/count/status        tvalid/tready
//                 tuser[0] kind
//  cfg_*     in   cfg_data[7:0] max_data_len               cfg_we, no wait
//
//  One character per cycle while s_tready is high; each character goes
//  through the input register, and its result then through the result queue.
//  Reset: max_data_len 20, decoder idle until a ':' arrives.
//  s_tready drops once queued results plus the word in the input register
//  reach the queue depth, so m_tready low stalls input once the queue fills.
module modbus_ascii_frame_decoder_core #(
    parameter int OUTQ_DEPTH = mafd_pkg::OUTQ_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] char_in
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,    // [7:0] data_byte, [15:8] frame_address,
                                    // [23:16] frame_function, [31:24] data_count,
                                    // [33:32] status, [39:34] zero
    output logic [0:0]  m_tuser     // [0] kind
);
    import mafd_pkg::*;

    localparam int LVL_W = $clog2(OUTQ_DEPTH + 1);

    logic             in_flight;
    logic             res_valid;
    result_t          res;
    result_t          q_data;
    logic [LVL_W-1:0] level;

    assign s_tready = (({1'b0, level} + {{LVL_W{1'b0}}, in_flight}) <
                       (LVL_W + 1)'(OUTQ_DEPTH));

    mafd_step u_step (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .in_valid  (s_tvalid && s_tready),
        .in_char   (s_tdata),
        .in_flight (in_flight),
        .res_valid (res_valid),
        .res       (res)
    );

    mafd_outq #(
        .DEPTH (OUTQ_DEPTH)
    ) u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_data  (q_data),
        .level     (level)
    );

    assign m_tdata = {6'd0, q_data.status, q_data.data_count, q_data.frame_function,
                      q_data.frame_address, q_data.data_byte};
    assign m_tuser = q_data.kind;

endmodule

>>> sim/modbus_ascii_frame_decoder_core_test.sv
// Self-checking testbench for the Modbus ASCII frame decoder core.
module modbus_ascii_frame_decoder_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import mafd_pkg::*;

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    localparam logic KIND_DATA    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    localparam int SETTLE_CYCLES  = 6;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 10;

    typedef enum logic [3:0] {
        HUNT, ADDR_HI, ADDR_LO, FUNC_HI, FUNC_LO, BODY_HI, BODY_LO, WAIT_LF
    } phase_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        cfg_we   = 1'b0;
    logic [7:0]  cfg_data = 8'd0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'd0;   // [7:0] char_in
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;           // [7:0] data_byte, [15:8] frame_address,
                                    // [23:16] frame_function, [31:24] data_count,
                                    // [33:32] status
    logic [0:0]  m_tuser;           // [0] kind

    // decoder shadow state
    phase_t     frame_phase = HUNT;
    logic [3:0] hi_nib      = 4'd0;
    logic [7:0] addr_byte   = 8'd0;
    logic [7:0] func_byte   = 8'd0;
    logic [7:0] held_byte   = 8'd0;
    logic       held_valid  = 1'b0;
    logic [7:0] sum_byte    = 8'd0;
    logic [7:0] data_cnt    = 8'd0;
    logic [1:0] err_status  = ST_OK;
    logic [7:0] data_limit  = MAX_LEN_RESET;

    result_t frame_results_q[$];
    result_t got_word;
    result_t want_word;

    int stall_pct    = 0;
    int chars_sent   = 0;
    int frame_chars  = 0;
    int data_words   = 0;
    int mismatches   = 0;
    int quiet_cycles = 0;
    int status_seen[4] = '{0, 0, 0, 0};

    modbus_ascii_frame_decoder_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 clk = ~clk;

    task automatic queue_result(input logic k, input logic [7:0] d, input logic [1:0] st);
        result_t r;
        r.kind           = k;
        r.data_byte      = d;
        r.frame_address  = addr_byte;
        r.frame_function = func_byte;
        r.data_count     = data_cnt;
        r.status         = st;
        frame_results_q.push_back(r);
    endtask

    task automatic open_frame();
        frame_phase = ADDR_HI;
        hi_nib      = 4'd0;
        addr_byte   = 8'd0;
        func_byte   = 8'd0;
        held_byte   = 8'd0;
        held_valid  = 1'b0;
        sum_byte    = 8'd0;
        data_cnt    = 8'd0;
        err_status  = ST_OK;
    endtask

    // advance the shadow decoder by one accepted character
    task automatic decode_char(input logic [7:0] c);
        logic [3:0] nib;
        logic [7:0] b;
        if (frame_phase != HUNT || c == CH_COLON)
            frame_chars++;
        nib = 4'd0;
        if (c >= "0" && c <= "9")
            nib = 4'(c - "0");
        else if (c >= "a" && c <= "f")
            nib = 4'(c - "a" + 8'd10);
        else if (c >= "A" && c <= "F")
            nib = 4'(c - "A" + 8'd10);
        b = {hi_nib, nib};

        if (frame_phase == HUNT)
        begin
            if (c == CH_COLON)
                open_frame();
        end
        else if (c == CH_COLON)
        begin
            queue_result(KIND_SUMMARY, 8'd0, ST_FORMAT);
            open_frame();
        end
        else if (frame_phase == WAIT_LF)
        begin
            if (c != CH_LF)
                queue_result(KIND_SUMMARY, 8'd0, ST_FORMAT);
            else if (err_status != ST_OK)
                queue_result(KIND_SUMMARY, 8'd0, err_status);
            else
                queue_result(KIND_SUMMARY, 8'd0, (sum_byte == held_byte) ? ST_OK : ST_MISMATCH);
            frame_phase = HUNT;
        end
        else if (c == CH_CR)
        begin
            if (frame_phase != BODY_HI || !held_valid)
                err_status = ST_FORMAT;
            frame_phase = WAIT_LF;
        end
        else
        begin
            case (frame_phase)
                ADDR_HI:
                begin
                    hi_nib = nib;
                    frame_phase = ADDR_LO;
                end
                FUNC_HI:
                begin
                    hi_nib = nib;
                    frame_phase = FUNC_LO;
                end
                BODY_HI:
                begin
                    hi_nib = nib;
                    frame_phase = BODY_LO;
                end
                ADDR_LO:
                begin
                    addr_byte = b;
                    sum_byte  = sum_byte + b;
                    frame_phase = FUNC_HI;
                end
                FUNC_LO:
                begin
                    func_byte = b;
                    sum_byte  = sum_byte + b;
                    frame_phase = BODY_HI;
                end
                BODY_LO:
                begin
                    frame_phase = BODY_HI;
                    if (!held_valid)
                    begin
                        held_byte  = b;
                        held_valid = 1'b1;
                    end
                    else
                    begin
                        // previous byte was not the check byte after all
                        sum_byte = sum_byte + held_byte;
                        if (data_cnt < data_limit)
                        begin
                            data_cnt = data_cnt + 8'd1;
                            queue_result(KIND_DATA, held_byte, ST_OK);
                        end
                        else
                        begin
                            if (data_cnt == data_limit && data_limit != 8'hFF)
                                data_cnt = data_cnt + 8'd1;
                            if (err_status == ST_OK)
                                err_status = ST_TOO_LONG;
                        end
                        held_byte = b;
                    end
                end
                default:
                    frame_phase = HUNT;
            endcase
        end
    endtask

    task automatic send_char(input logic [7:0] c);
        if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        do @(posedge clk); while (!s_tready);
        decode_char(c);
        chars_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i]);
    endtask

    task automatic send_crlf();
        send_char(CH_CR);
        send_char(CH_LF);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10)
            return "0" + n;
        return ($urandom_range(0, 1) ? "A" : "a") + n - 8'd10;
    endfunction

    // pipeline empty: no word expected and nothing left in flight
    task automatic drain();
        s_tvalid <= 1'b0;
        while (frame_results_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_data_limit(input logic [7:0] v);
        drain();
        cfg_data <= v;
        cfg_we   <= 1'b1;
        @(posedge clk);
        cfg_we     <= 1'b0;
        data_limit  = v;
    endtask

    // one frame with random content; when not clean, possibly damaged
    task automatic send_frame(input int n_body, input bit clean);
        logic [7:0] frame_bytes[$];
        logic [7:0] line[$];
        logic [7:0] chk;
        logic [7:0] b;
        int flaw;
        int keep;
        frame_bytes.push_back(8'($urandom_range(0, 255)));
        frame_bytes.push_back(8'($urandom_range(0, 255)));
        repeat (n_body) frame_bytes.push_back(8'($urandom_range(0, 255)));
        chk = 8'd0;
        foreach (frame_bytes[i])
            chk = chk + frame_bytes[i];
        if (!clean && $urandom_range(0, 4) == 0)
            chk = 8'($urandom_range(0, 255));
        frame_bytes.push_back(chk);
        flaw = clean ? 0 : $urandom_range(0, 11);
        if (flaw == 8)
        begin
            keep = $urandom_range(0, 2);
            while (frame_bytes.size() > keep)
                frame_bytes.delete(frame_bytes.size() - 1);
        end
        line.push_back(CH_COLON);
        foreach (frame_bytes[i])
        begin
            b = frame_bytes[i];
            line.push_back(hex_char(b[7:4]));
            line.push_back(hex_char(b[3:0]));
        end
        line.push_back(CH_CR);
        line.push_back(CH_LF);
        case (flaw)
            9:  line.insert($urandom_range(1, line.size() - 1), 8'($urandom_range(0, 255)));
            10: line.delete($urandom_range(1, line.size() - 3));
            11: line[line.size() - 1] = 8'($urandom_range(0, 255));
            default: ;
        endcase
        foreach (line[i])
            send_char(line[i]);
    endtask

    task automatic report_mismatch(input string what, input result_t want, input result_t got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
        begin
            $display("%0t %s: expected kind %0d data %h addr %h func %h count %0d status %0d",
                     $time, what, want.kind, want.data_byte, want.frame_address,
                     want.frame_function, want.data_count, want.status);
            $display("    got kind %0d data %h addr %h func %h count %0d status %0d",
                     got.kind, got.data_byte, got.frame_address, got.frame_function,
                     got.data_count, got.status);
        end
    endtask

    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
        begin
            got_word.kind           = m_tuser[0];
            got_word.data_byte      = m_tdata[7:0];
            got_word.frame_address  = m_tdata[15:8];
            got_word.frame_function = m_tdata[23:16];
            got_word.data_count     = m_tdata[31:24];
            got_word.status         = m_tdata[33:32];
            if (frame_results_q.size() == 0)
                report_mismatch("word with nothing expected", '0, got_word);
            else
            begin
                want_word = frame_results_q.pop_front();
                if (got_word.kind !== want_word.kind
                    || got_word.data_byte !== want_word.data_byte
                    || got_word.frame_address !== want_word.frame_address
                    || got_word.frame_function !== want_word.frame_function
                    || got_word.data_count !== want_word.data_count
                    || got_word.status !== want_word.status)
                    report_mismatch("word mismatch", want_word, got_word);
                if (want_word.kind == KIND_DATA)
                    data_words++;
                else
                    status_seen[want_word.status]++;
            end
        end
    end

    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("watchdog: no handshake for %0d cycles, %0d words still expected",
                 WATCHDOG_LIMIT, frame_results_q.size());
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic test_clean_frames();
        send_char(8'h00);
        send_char(8'hFF);
        send_text(":0103220026");
        send_crlf();
        send_text(":fF0e0D");
        send_crlf();
    endtask

    // non-hex characters, a lone LF included, decode as zero
    task automatic test_bad_digits();
        send_text(":G1");
        send_char(CH_LF);
        send_text("z0100");
        send_crlf();
    endtask

    task automatic test_frame_aborts();
        send_text(":0102:0102");
        send_char(CH_CR);
        send_text(":01");
        send_char(CH_CR);
        send_text("x");
    endtask

    task automatic test_format_errors();
        send_text(":0");
        send_crlf();
        send_text(":01020");
        send_crlf();
        send_text(":0102");
        send_crlf();
        send_text(":010203");
        send_crlf();
    endtask

    task automatic test_too_long();
        set_data_limit(8'd0);
        send_text(":0102AABB77");
        send_crlf();
        send_text(":0102AABBC");
        send_crlf();
    endtask

    task automatic test_limit_lowered();
        set_data_limit(8'd3);
        send_text(":0102AABBCC");
        set_data_limit(8'd1);
        send_text("DDEE");
        send_crlf();
    endtask

    task automatic test_long_frame();
        set_data_limit(8'd252);
        send_frame(8, 1);
        send_frame(254, 1);
    endtask

    task automatic test_random_traffic(input logic [7:0] limit, input int n_chars, input int stalls);
        int target;
        int body_cap;
        set_data_limit(limit);
        stall_pct = stalls;
        body_cap  = (limit < 8'd10) ? limit + 2 : 10;
        target    = frame_chars + n_chars;
        while (frame_chars < target)
        begin
            send_frame($urandom_range(0, body_cap), 0);
            if ($urandom_range(0, 5) == 0)
                repeat ($urandom_range(1, 3)) send_char(8'($urandom_range(0, 255)));
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        stall_pct = 20;

        test_clean_frames();
        test_bad_digits();
        test_frame_aborts();
        test_format_errors();
        test_too_long();
        test_limit_lowered();
        test_long_frame();

        test_random_traffic(8'd20, 80, 20);
        test_random_traffic(8'd0, 60, 35);
        test_random_traffic(8'd1, 60, 0);
        test_random_traffic(8'd252, 80, 10);
        test_random_traffic(8'($urandom_range(2, 251)), 80, 25);
        test_random_traffic(8'd5, 60, 0);
        drain();

        $display("sent %0d characters, %0d of them inside frames, max_data_len from 0 to 252",
                 chars_sent, frame_chars);
        $display("checked %0d data words; ends: %0d ok, %0d format, %0d too long, %0d mismatch",
                 data_words, status_seen[ST_OK], status_seen[ST_FORMAT],
                 status_seen[ST_TOO_LONG], status_seen[ST_MISMATCH]);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/mafd_pkg.sv
rtl/mafd_step.sv
rtl/mafd_outq.sv
rtl/modbus_ascii_frame_decoder_core.sv
sim/modbus_ascii_frame_decoder_core_test.sv
